/* design/rcsr_pkg.sv */
// Shared types, codes and constants of the CSR and trap-return unit.
`timescale 1ns / 1ps
`default_nettype none

package rcsr_pkg;

  // Default sizes of the CSR store.
  localparam int CSR_ADDR_BITS_DEF = 12;
  localparam int XLEN_DEF          = 64;

  // Width of the CSR number field in the instruction word.
  localparam int CSR_NUM_W = 12;

  // Command queue between decode and execute.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Opcodes and fixed system instruction words.
  localparam logic [6:0]  OPC_SYSTEM  = 7'b1110011;
  localparam logic [6:0]  OPC_MISCMEM = 7'b0001111;
  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
  localparam logic [31:0] WORD_URET   = 32'h0020_0073;
  localparam logic [31:0] WORD_SRET   = 32'h1020_0073;
  localparam logic [31:0] WORD_HRET   = 32'h2020_0073;
  localparam logic [31:0] WORD_MRET   = 32'h3020_0073;

  // funct3 values of interest.
  localparam logic [2:0] F3_PRIV   = 3'b000;
  localparam logic [2:0] F3_UNUSED = 3'b100;

  // Low two funct3 bits of the CSR forms.
  localparam logic [1:0] CSR_OP_RW = 2'b01;
  localparam logic [1:0] CSR_OP_RS = 2'b10;
  localparam logic [1:0] CSR_OP_RC = 2'b11;

  // Privilege levels.
  localparam logic [1:0] LVL_U = 2'd0;
  localparam logic [1:0] LVL_S = 2'd1;
  localparam logic [1:0] LVL_H = 2'd2;
  localparam logic [1:0] LVL_M = 2'd3;

  // Exception codes.
  localparam logic [1:0] EXC_ILLEGAL = 2'd0;
  localparam logic [1:0] EXC_BREAK   = 2'd1;
  localparam logic [1:0] EXC_CALL_M  = 2'd2;
  localparam logic [1:0] EXC_CALL_U  = 2'd3;

  // CSR numbers and reset contents.
  localparam logic [CSR_NUM_W-1:0] CSRNUM_STATUS = 12'h300;
  localparam logic [CSR_NUM_W-1:0] CSRNUM_ISA    = 12'h301;
  localparam logic [7:0]           EPC_OFFSET    = 8'h41;
  localparam logic [31:0]          MISA_RESET    = 32'h0014_0080;

  // mstatus bit positions.
  localparam int MS_UIE  = 0;
  localparam int MS_SIE  = 1;
  localparam int MS_HIE  = 2;
  localparam int MS_MIE  = 3;
  localparam int MS_UPIE = 4;
  localparam int MS_SPIE = 5;
  localparam int MS_HPIE = 6;
  localparam int MS_MPIE = 7;
  localparam int MS_SPP  = 8;
  localparam int MS_HPP  = 9;
  localparam int MS_MPP  = 11;

  typedef enum logic [2:0] {
    CMD_CSR,
    CMD_XRET,
    CMD_ECALL,
    CMD_EBREAK,
    CMD_NOP,
    CMD_ILLEGAL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC
  } exec_state_t;

  // Decoded command handed from decode to execute.
  typedef struct packed {
    cmd_kind_t            kind;
    logic [1:0]           csr_op;
    logic [CSR_NUM_W-1:0] csr_num;
    logic [63:0]          operand;
    logic [4:0]           rd;
    logic [1:0]           xret_lvl;
  } cmd_t;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] rs1_value;
  } csr_req_t;

  typedef struct packed {
    logic        rd_write;
    logic [4:0]  rd_index;
    logic [63:0] rd_value;
    logic        branch_taken;
    logic [63:0] branch_target;
    logic        exception_raised;
    logic [1:0]  exception_code;
    logic [1:0]  privilege;
  } csr_rsp_t;

endpackage

`default_nettype wire

/* design/riscv_csr_and_trap_return_unit.sv */
// Top level of the CSR and trap-return unit.
//
// The unit executes RISC-V system instructions: the six Zicsr forms, the
// four trap returns, ECALL, EBREAK and the two fences. An instruction word
// and the rs1 value arrive as one word on the insn channel; each one gives
// exactly one word on the result channel, in order, carrying the rd write,
// the return target, any exception and the privilege level afterwards.
//
// A word taken from the insn channel is written into the command queue;
// execute pops it with a registered read of the CSR store, then writes the
// store and loads the result register once the receiver is ready. Execute
// finishes one instruction before it pops the next.
//
// A two-entry command queue sits between decode and execute, so decode keeps
// taking words while a finished result waits in the output register. When the
// receiver stalls, the result word holds, execute waits, and the queue fills;
// insn_ready then drops until space frees up. After reset the store is
// initialized by a pass over all 2^CSR_ADDR_BITS entries (4096 by default) with
// insn_ready low; the level resets to machine mode and misa comes up with the
// U, S and H bits set.
`timescale 1ns / 1ps
`default_nettype none

module riscv_csr_and_trap_return_unit
  import rcsr_pkg::*;
#(
  parameter int CSR_ADDR_BITS = CSR_ADDR_BITS_DEF,
  parameter int XLEN          = XLEN_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     insn_valid,
  output logic          insn_ready,
  input  wire csr_req_t insn_word,
  output logic          result_valid,
  input  wire logic     result_ready,
  output csr_rsp_t      result_word
);

  logic clearing;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t q_cmd;

  // Decode: classifies each accepted word into a command.
  rcsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .insn_valid (insn_valid),
    .insn_ready (insn_ready),
    .insn_word  (insn_word),
    .clearing   (clearing),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Decoupling queue between the two sides.
  rcsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Execute: owns the CSR store, the privilege level and the result register.
  rcsr_back #(
    .CSR_ADDR_BITS (CSR_ADDR_BITS),
    .XLEN          (XLEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_cmd        (q_cmd),
    .q_empty      (q_empty),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

endmodule

`default_nettype wire

/* design/rcsr_front.sv */
// Decode stage: accepts instruction words and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none

module rcsr_front
  import rcsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     insn_valid,
  output logic          insn_ready,
  input  wire csr_req_t insn_word,
  input  wire logic     clearing,
  input  wire logic     q_full,
  output logic          push,
  output cmd_t          push_cmd
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [31:0] insn;
  logic is_xret;

  assign insn = insn_word.instruction;
  assign opc  = insn[6:0];
  assign f3   = insn[14:12];

  assign is_xret = (insn == WORD_URET) || (insn == WORD_SRET) ||
                   (insn == WORD_HRET) || (insn == WORD_MRET);

  // Nothing is taken while the store is being initialized.
  assign insn_ready = !clearing && !q_full && !rst;
  assign push       = insn_valid && insn_ready;

  always_comb begin
    push_cmd          = '0;
    push_cmd.kind     = CMD_ILLEGAL;
    push_cmd.csr_op   = f3[1:0];
    push_cmd.csr_num  = insn[31:20];
    push_cmd.rd       = insn[11:7];
    push_cmd.xret_lvl = insn[29:28];
    // Immediate forms use the rs1 field as a zero-extended operand.
    push_cmd.operand  = f3[2] ? {59'd0, insn[19:15]} : insn_word.rs1_value;
    if ((opc == OPC_SYSTEM) && (f3 != F3_PRIV) && (f3 != F3_UNUSED)) begin
      push_cmd.kind = CMD_CSR;
    end else if (is_xret) begin
      push_cmd.kind = CMD_XRET;
    end else if (insn == WORD_ECALL) begin
      push_cmd.kind = CMD_ECALL;
    end else if (insn == WORD_EBREAK) begin
      push_cmd.kind = CMD_EBREAK;
    end else if ((opc == OPC_MISCMEM) && (f3[2:1] == 2'b00)) begin
      push_cmd.kind = CMD_NOP;
    end
  end

  // Clock is not used by the decoder itself; it is kept for a uniform port list.
  logic unused_clk;
  assign unused_clk = clk;

endmodule

`default_nettype wire

/* design/rcsr_queue.sv */
// Short command queue between the decode and execute stages.
`timescale 1ns / 1ps
`default_nettype none

module rcsr_queue
  import rcsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      full,
  output logic      empty
);

  cmd_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* design/rcsr_back.sv */
// Execute stage: CSR store, privilege level, trap return and result register.
`timescale 1ns / 1ps
`default_nettype none

module rcsr_back
  import rcsr_pkg::*;
#(
  parameter int CSR_ADDR_BITS = CSR_ADDR_BITS_DEF,
  parameter int XLEN          = XLEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t q_cmd,
  input  wire logic q_empty,
  output logic      pop,
  output logic      clearing,
  output logic      result_valid,
  input  wire logic result_ready,
  output csr_rsp_t  result_word
);

  localparam int DEPTH = 1 << CSR_ADDR_BITS;
  localparam logic [CSR_ADDR_BITS-1:0] MSTATUS_A = CSR_ADDR_BITS'(CSRNUM_STATUS);
  localparam logic [CSR_ADDR_BITS-1:0] MISA_A    = CSR_ADDR_BITS'(CSRNUM_ISA);
  localparam logic [XLEN-1:0]          MISA_VAL  = XLEN'(MISA_RESET);

  logic [XLEN-1:0] mem [DEPTH];

  exec_state_t state;
  exec_state_t state_next;
  logic [CSR_ADDR_BITS-1:0] clr_addr;
  logic [1:0] level;
  logic [1:0] level_next;
  cmd_t cmd;
  logic [XLEN-1:0] rdata_a;
  logic [XLEN-1:0] rdata_b;
  csr_rsp_t rsp_next;

  logic                     out_free;
  logic                     fire;
  logic                     we;
  logic [CSR_ADDR_BITS-1:0] waddr;
  logic [XLEN-1:0]          wdata;
  logic [CSR_ADDR_BITS-1:0] raddr_a;
  logic [CSR_ADDR_BITS-1:0] raddr_b;
  logic [XLEN-1:0]          operand;
  logic [XLEN-1:0]          csr_new;
  logic [XLEN-1:0]          ms_new;
  logic [1:0]               xret_level;

  assign out_free = !result_valid || result_ready;
  assign fire     = (state == ST_EXEC) && out_free;
  assign clearing = (state == ST_CLEAR);

  // Read addresses come straight from the queue head when it is taken.
  assign raddr_a = (q_cmd.kind == CMD_XRET) ? MSTATUS_A : q_cmd.csr_num[CSR_ADDR_BITS-1:0];
  assign raddr_b = CSR_ADDR_BITS'({q_cmd.xret_lvl, EPC_OFFSET});

  // New CSR value for the read-modify-write forms.
  assign operand = cmd.operand[XLEN-1:0];
  always_comb begin
    case (cmd.csr_op)
      CSR_OP_RW: csr_new = operand;
      CSR_OP_RS: csr_new = rdata_a | operand;
      default:   csr_new = rdata_a & ~operand;
    endcase
  end

  // mstatus update and new level of a legal trap return.
  always_comb begin
    ms_new     = rdata_a;
    xret_level = level;
    case (cmd.xret_lvl)
      LVL_U: begin
        ms_new[MS_UIE]  = 1'b0;
        ms_new[MS_UPIE] = 1'b0;
        xret_level      = LVL_U;
      end
      LVL_S: begin
        ms_new[MS_SIE]  = rdata_a[MS_SPIE];
        ms_new[MS_SPIE] = 1'b1;
        ms_new[MS_SPP]  = 1'b0;
        xret_level      = {1'b0, rdata_a[MS_SPP]};
      end
      LVL_H: begin
        ms_new[MS_HIE]             = rdata_a[MS_HPIE];
        ms_new[MS_HPIE]            = 1'b1;
        ms_new[MS_HPP+1:MS_HPP]    = 2'b00;
        xret_level                 = rdata_a[MS_HPP+1:MS_HPP];
      end
      default: begin
        ms_new[MS_MIE]             = rdata_a[MS_MPIE];
        ms_new[MS_MPIE]            = 1'b1;
        ms_new[MS_MPP+1:MS_MPP]    = 2'b00;
        xret_level                 = rdata_a[MS_MPP+1:MS_MPP];
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_addr) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!q_empty) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_FETCH;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: store write, queue pop, result and level.
  always_comb begin
    pop        = (state == ST_FETCH) && !q_empty;
    we         = 1'b0;
    waddr      = cmd.csr_num[CSR_ADDR_BITS-1:0];
    wdata      = csr_new;
    level_next = level;
    rsp_next           = '0;
    rsp_next.privilege = level;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = (clr_addr == MISA_A) ? MISA_VAL : '0;
      end
      ST_EXEC: begin
        case (cmd.kind)
          CMD_CSR: begin
            we                = fire;
            rsp_next.rd_index = cmd.rd;
            if (cmd.rd != 5'd0) begin
              rsp_next.rd_write = 1'b1;
              rsp_next.rd_value = 64'(rdata_a);
            end
          end
          CMD_XRET: begin
            if (level == cmd.xret_lvl) begin
              we                     = fire;
              waddr                  = MSTATUS_A;
              wdata                  = ms_new;
              rsp_next.branch_taken  = 1'b1;
              rsp_next.branch_target = 64'(rdata_b);
              rsp_next.privilege     = xret_level;
              if (fire) begin
                level_next = xret_level;
              end
            end else begin
              rsp_next.exception_raised = 1'b1;
              rsp_next.exception_code   = EXC_ILLEGAL;
            end
          end
          CMD_ECALL: begin
            if (level == LVL_M) begin
              rsp_next.exception_raised = 1'b1;
              rsp_next.exception_code   = EXC_CALL_M;
            end else if (level == LVL_U) begin
              rsp_next.exception_raised = 1'b1;
              rsp_next.exception_code   = EXC_CALL_U;
            end
          end
          CMD_EBREAK: begin
            rsp_next.exception_raised = 1'b1;
            rsp_next.exception_code   = EXC_BREAK;
          end
          CMD_NOP: begin
            rsp_next.privilege = level;
          end
          default: begin
            rsp_next.exception_raised = 1'b1;
            rsp_next.exception_code   = EXC_ILLEGAL;
          end
        endcase
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      level        <= LVL_M;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
    end
    if (fire) begin
      result_word <= rsp_next;
    end
  end

  // CSR store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* design/rcsr_checker.sv */
// Port-level checker for the CSR unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rcsr_checker
  import rcsr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     insn_valid,
  input wire logic     insn_ready,
  input wire csr_req_t insn_word,
  input wire logic     result_valid,
  input wire logic     result_ready,
  input wire csr_rsp_t result_word
);

  // Reset empties the result register and starts the store initialization.
  assert property (@(posedge clk) rst |=> !result_valid && !insn_ready)
    else $error("result or input ready right after reset");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("stalled result word changed");

  // A trap return that branches never raises an exception as well.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_word.branch_taken && result_word.exception_raised))
    else $error("branch and exception in one result");

  // An rd write always names a nonzero register.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.rd_write |-> result_word.rd_index != 5'd0)
    else $error("rd write to x0");

  // An environment call from machine mode reports machine mode as its level.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_word.exception_raised &&
    (result_word.exception_code == EXC_CALL_M) |-> result_word.privilege == LVL_M)
    else $error("call from M reported outside machine mode");

  logic unused_in;
  assign unused_in = insn_valid ^ (^insn_word);

endmodule

bind riscv_csr_and_trap_return_unit rcsr_checker u_rcsr_checker (.*);

`default_nettype wire

/* test/tb_riscv_csr_and_trap_return_unit.sv */
// Self-checking testbench for the CSR and trap-return unit.
`timescale 1ns / 1ps

module tb_riscv_csr_and_trap_return_unit;
  import rcsr_pkg::*;

  // Fence funct3 values and a plain ALU opcode used for unmatched words.
  localparam logic [2:0] F3_FENCE   = 3'b000;
  localparam logic [2:0] F3_FENCE_I = 3'b001;
  localparam logic [6:0] OPC_ALU    = 7'b0110011;

  localparam int STORE_DEPTH  = 1 << CSR_ADDR_BITS_DEF;
  localparam int RANDOM_INSNS = 650;
  localparam int HOLD_CYCLES  = 80;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     insn_valid = 1'b0;
  logic     insn_ready;
  csr_req_t insn_word = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  csr_rsp_t result_word;

  riscv_csr_and_trap_return_unit dut (
    .clk          (clk),
    .rst          (rst),
    .insn_valid   (insn_valid),
    .insn_ready   (insn_ready),
    .insn_word    (insn_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

  // Instruction words waiting to be offered, and the results predicted for the
  // words the unit has already taken, oldest first.
  csr_req_t pending_insns[$];
  csr_rsp_t predicted_rsps[$];

  // The predictor's own copy of the CSR store and the privilege level.
  logic [63:0] csr_mem [0:STORE_DEPTH-1];
  logic [1:0]  cur_lvl;

  // Privilege level the stimulus generator expects the unit to be in. It only
  // steers the stimulus; the checking never depends on it.
  logic [1:0]  plan_lvl;

  int insns_accepted = 0;
  int rsps_checked   = 0;
  int total_insns    = 1;
  int err_count      = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the handshake hangs. The slowest correct run, with the
  // clearing pass after reset and heavy idling on both sides, needs well under
  // a tenth of this.
  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Predictor: executes one system instruction against the local state and
  // returns the result word the unit must produce for it.
  //--------------------------------------------------------------------------
  function automatic csr_rsp_t execute_system(csr_req_t req);
    logic [31:0] w;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [11:0] num;
    logic [63:0] src;
    logic [63:0] old;
    logic [63:0] nv;
    logic [63:0] ms;
    logic [1:0]  lvl;
    csr_rsp_t    r;
    w   = req.instruction;
    rd  = w[11:7];
    f3  = w[14:12];
    num = w[31:20];
    r   = '0;
    if (w[6:0] == OPC_SYSTEM && f3 != F3_PRIV && f3 != F3_UNUSED) begin
      // Immediate forms take the 5-bit zimm from the rs1 field.
      src = f3[2] ? {59'd0, w[19:15]} : req.rs1_value;
      old = csr_mem[num];
      case (f3[1:0])
        CSR_OP_RW: nv = src;
        CSR_OP_RS: nv = old | src;
        default:   nv = old & ~src;
      endcase
      r.rd_index = rd;
      if (rd != 5'd0) begin
        r.rd_write = 1'b1;
        r.rd_value = old;
      end
      csr_mem[num] = nv;
    end else if (w == WORD_URET || w == WORD_SRET || w == WORD_HRET || w == WORD_MRET) begin
      lvl = w[29:28];
      if (lvl != cur_lvl) begin
        r.exception_raised = 1'b1;
        r.exception_code   = EXC_ILLEGAL;
      end else begin
        ms = csr_mem[CSRNUM_STATUS];
        r.branch_taken  = 1'b1;
        r.branch_target = csr_mem[{2'b00, lvl, EPC_OFFSET}];
        case (lvl)
          LVL_U: begin
            ms[MS_UIE]  = 1'b0;
            ms[MS_UPIE] = 1'b0;
          end
          LVL_S: begin
            ms[MS_SIE]  = ms[MS_SPIE];
            ms[MS_SPIE] = 1'b1;
            cur_lvl     = {1'b0, ms[MS_SPP]};
            ms[MS_SPP]  = 1'b0;
          end
          LVL_H: begin
            ms[MS_HIE]     = ms[MS_HPIE];
            ms[MS_HPIE]    = 1'b1;
            cur_lvl        = ms[MS_HPP +: 2];
            ms[MS_HPP +: 2] = LVL_U;
          end
          default: begin
            ms[MS_MIE]     = ms[MS_MPIE];
            ms[MS_MPIE]    = 1'b1;
            cur_lvl        = ms[MS_MPP +: 2];
            ms[MS_MPP +: 2] = LVL_U;
          end
        endcase
        csr_mem[CSRNUM_STATUS] = ms;
      end
    end else if (w == WORD_ECALL) begin
      // Calls from S and H pass through without any effect.
      if (cur_lvl == LVL_M) begin
        r.exception_raised = 1'b1;
        r.exception_code   = EXC_CALL_M;
      end else if (cur_lvl == LVL_U) begin
        r.exception_raised = 1'b1;
        r.exception_code   = EXC_CALL_U;
      end
    end else if (w == WORD_EBREAK) begin
      r.exception_raised = 1'b1;
      r.exception_code   = EXC_BREAK;
    end else if (!(w[6:0] == OPC_MISCMEM && (f3 == F3_FENCE || f3 == F3_FENCE_I))) begin
      r.exception_raised = 1'b1;
      r.exception_code   = EXC_ILLEGAL;
    end
    r.privilege = cur_lvl;
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Stimulus helpers.
  //--------------------------------------------------------------------------
  function automatic logic [31:0] csr_insn(logic [1:0] op, logic imm, logic [4:0] rd,
                                           logic [4:0] src, logic [11:0] num);
    return {num, src, imm, op, rd, OPC_SYSTEM};
  endfunction

  function automatic logic [31:0] xret_word(logic [1:0] lvl);
    case (lvl)
      LVL_U:   return WORD_URET;
      LVL_S:   return WORD_SRET;
      LVL_H:   return WORD_HRET;
      default: return WORD_MRET;
    endcase
  endfunction

  function automatic logic [11:0] epc_num(logic [1:0] lvl);
    return {2'b00, lvl, EPC_OFFSET};
  endfunction

  // Operand values lean toward the extremes and single set bits.
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(5))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Most accesses go to a small pool of CSRs so that reads see earlier writes.
  function automatic logic [11:0] pick_csr_num();
    logic [1:0]  lvl;
    logic [11:0] any;
    lvl = 2'($urandom_range(3));
    any = 12'($urandom);
    case ($urandom_range(9))
      0:       return CSRNUM_STATUS;
      1:       return CSRNUM_ISA;
      2, 3:    return epc_num(lvl);
      4:       return 12'h000;
      5:       return 12'hFFF;
      default: return any;
    endcase
  endfunction

  task automatic queue_insn(logic [31:0] w, logic [63:0] v);
    csr_req_t r;
    r.instruction = w;
    r.rs1_value   = v;
    pending_insns.push_back(r);
  endtask

  task automatic queue_random_csr();
    logic [1:0] op;
    logic [4:0] rd;
    case ($urandom_range(2))
      0:       op = CSR_OP_RW;
      1:       op = CSR_OP_RS;
      default: op = CSR_OP_RC;
    endcase
    rd = ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom);
    queue_insn(csr_insn(op, 1'($urandom), rd, 5'($urandom), pick_csr_num()), rand_operand());
  endtask

  // A well-formed return: load mstatus with the wanted previous-privilege
  // field, load the xEPC of the current level, then issue its xRET.
  task automatic queue_return(logic [1:0] from_lvl, logic [1:0] to_lvl);
    logic [63:0] ms;
    ms = rand_operand();
    case (from_lvl)
      LVL_M: ms[MS_MPP +: 2] = to_lvl;
      LVL_H: ms[MS_HPP +: 2] = to_lvl;
      LVL_S: ms[MS_SPP]      = to_lvl[0];
      default: ;
    endcase
    queue_insn(csr_insn(CSR_OP_RW, 1'b0, 5'($urandom), 5'($urandom), CSRNUM_STATUS), ms);
    queue_insn(csr_insn(CSR_OP_RW, 1'b0, 5'($urandom), 5'($urandom), epc_num(from_lvl)),
               rand_operand());
    queue_insn(xret_word(from_lvl), rand_operand());
    plan_lvl = (from_lvl == LVL_U) ? LVL_U : to_lvl;
  endtask

  // Everything other than CSR accesses and well-formed returns.
  task automatic queue_other();
    logic [31:0] w;
    logic [2:0]  f3;
    logic [1:0]  lvl;
    w = $urandom;
    case ($urandom_range(9))
      0: w = WORD_ECALL;
      1: w = WORD_EBREAK;
      2: begin
        w[6:0]   = OPC_MISCMEM;
        w[14:12] = ($urandom_range(1) != 0) ? F3_FENCE_I : F3_FENCE;
      end
      3: begin
        f3 = 3'($urandom_range(7, 2));
        w[6:0]   = OPC_MISCMEM;
        w[14:12] = f3;
      end
      4: begin
        w[6:0]   = OPC_SYSTEM;
        w[14:12] = F3_UNUSED;
      end
      5: begin
        w[6:0]   = OPC_SYSTEM;
        w[14:12] = F3_PRIV;
      end
      6: begin
        while (w[6:0] == OPC_SYSTEM || w[6:0] == OPC_MISCMEM) w = $urandom;
      end
      7: begin
        // A return issued from the wrong level.
        lvl = 2'($urandom_range(3));
        while (lvl == plan_lvl) lvl = 2'($urandom_range(3));
        w = xret_word(lvl);
      end
      8: begin
        // One bit away from a return word.
        lvl = 2'($urandom_range(3));
        w = xret_word(lvl) ^ (32'd1 << $urandom_range(31, 7));
      end
      default: ;
    endcase
    queue_insn(w, rand_operand());
  endtask

  //--------------------------------------------------------------------------
  // Idle control. The run is split in three by accepted words: first the
  // sender idles lightly and the receiver heavily, then the reverse, then
  // neither side idles.
  //--------------------------------------------------------------------------
  function automatic int idle_phase();
    if (insns_accepted * 3 < total_insns) return 0;
    if (insns_accepted * 3 < 2 * total_insns) return 1;
    return 2;
  endfunction

  function automatic int sender_gap_pct();
    case (idle_phase())
      0:       return 17;
      1:       return 65;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_phase())
      0:       return 65;
      1:       return 17;
      default: return 0;
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Driver. When the unit takes a word, its result is predicted right away,
  // since the unit answers in order and the predictor mirrors its state.
  // Valid only drops between words, never while a word is on offer.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      insn_valid <= 1'b0;
    end else begin
      if (insn_valid && insn_ready) begin
        predicted_rsps.push_back(execute_system(insn_word));
        insns_accepted++;
      end
      if (!insn_valid || insn_ready) begin
        if (pending_insns.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
          insn_valid <= 1'b1;
          insn_word  <= pending_insns.pop_front();
        end else begin
          insn_valid <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Long receiver hold. Once, in the phase without idling, the receiver holds
  // off while hold_left counts down, so the internal queue fills and
  // insn_ready drops.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && idle_phase() == 2 && rsps_checked * 6 >= 5 * total_insns) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  //--------------------------------------------------------------------------
  // Monitor. Each result word is checked field by field against the oldest
  // prediction.
  //--------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    csr_rsp_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (predicted_rsps.size() == 0) begin
          $error("result word arrived with no instruction outstanding");
          err_count++;
        end else begin
          want = predicted_rsps.pop_front();
          check_field("rd_write", want.rd_write, result_word.rd_write);
          check_field("rd_index", want.rd_index, result_word.rd_index);
          check_field("rd_value", want.rd_value, result_word.rd_value);
          check_field("branch_taken", want.branch_taken, result_word.branch_taken);
          check_field("branch_target", want.branch_target, result_word.branch_target);
          check_field("exception_raised", want.exception_raised,
                      result_word.exception_raised);
          check_field("exception_code", want.exception_code, result_word.exception_code);
          check_field("privilege", want.privilege, result_word.privilege);
        end
        rsps_checked++;
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus and end of run. All words are built up front: the generator
  // tracks the level it expects only to steer the returns, so the whole
  // sequence is known before reset is released.
  //--------------------------------------------------------------------------
  initial begin
    int         i;
    int         directed_cnt;
    int         k;
    int         pick;
    logic [1:0] to_lvl;

    for (i = 0; i < STORE_DEPTH; i++) csr_mem[i] = 64'd0;
    csr_mem[CSRNUM_ISA] = {32'd0, MISA_RESET};
    cur_lvl  = LVL_M;
    plan_lvl = LVL_M;

    // Directed part, starting in machine mode with mstatus clear.
    // Read misa to see its reset value, then exercise all six CSR forms with
    // extreme operands, extreme CSR numbers and a zero rd.
    queue_insn(csr_insn(CSR_OP_RS, 1'b0, 5'd1, 5'd0, CSRNUM_ISA), 64'd0);
    queue_insn(csr_insn(CSR_OP_RW, 1'b0, 5'd31, 5'd31, epc_num(LVL_M)), '1);
    queue_insn(csr_insn(CSR_OP_RS, 1'b0, 5'd5, 5'd0, epc_num(LVL_M)), 64'd0);
    queue_insn(csr_insn(CSR_OP_RC, 1'b0, 5'd0, 5'd3, epc_num(LVL_M)),
               64'hFFFF_0000_0000_FFFF);
    queue_insn(csr_insn(CSR_OP_RW, 1'b1, 5'd7, 5'd31, 12'hFFF), '1);
    queue_insn(csr_insn(CSR_OP_RS, 1'b1, 5'd8, 5'd0, 12'hFFF), 64'd0);
    queue_insn(csr_insn(CSR_OP_RC, 1'b1, 5'd9, 5'd21, 12'hFFF), '1);
    queue_insn(csr_insn(CSR_OP_RW, 1'b0, 5'd10, 5'd2, 12'h000), 64'h8000_0000_0000_0001);
    // Call from machine mode, breakpoint, both fences.
    queue_insn(WORD_ECALL, 64'd0);
    queue_insn(WORD_EBREAK, '1);
    queue_insn(32'h0FF0_000F, 64'd0);
    queue_insn(32'h0000_100F, 64'd0);
    // Unmatched words: a bad MISC-MEM funct3, SYSTEM funct3 100, another
    // funct3-000 SYSTEM word, and a non-system opcode.
    queue_insn(32'h0000_700F, 64'd0);
    queue_insn({CSRNUM_STATUS, 5'd1, F3_UNUSED, 5'd2, OPC_SYSTEM}, '1);
    queue_insn(32'h1050_0073, 64'd0);
    queue_insn({25'h0020_81B >> 0, OPC_ALU}, 64'd0);
    // Returns from levels other than the current one are illegal.
    queue_insn(WORD_URET, 64'd0);
    queue_insn(WORD_SRET, 64'd0);
    queue_insn(WORD_HRET, 64'd0);
    // Machine return down to H, a call there that has no effect, and a
    // hypervisor return back up to M.
    queue_return(LVL_M, LVL_H);
    queue_insn(WORD_ECALL, 64'd0);
    queue_return(LVL_H, LVL_M);
    directed_cnt = pending_insns.size();

    // Random part. The level wanders between M and H first, then settles in
    // S, and ends in U, since neither S nor U can climb back up.
    k = 0;
    while (k < RANDOM_INSNS) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        queue_random_csr();
      end else if (pick < 60) begin
        if (k < 390) to_lvl = ($urandom_range(1) != 0) ? LVL_M : LVL_H;
        else if (k < 530) to_lvl = LVL_S;
        else to_lvl = LVL_U;
        if (plan_lvl == LVL_S && to_lvl != LVL_U) to_lvl = LVL_S;
        queue_return(plan_lvl, to_lvl);
      end else begin
        queue_other();
      end
      k = pending_insns.size() - directed_cnt;
    end
    total_insns = pending_insns.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Sampling on the falling edge keeps clear of the updates made at the
    // rising edge by the driver and the monitor.
    while (pending_insns.size() != 0 || insn_valid || predicted_rsps.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    if (predicted_rsps.size() != 0) begin
      $error("%0d predicted results never arrived", predicted_rsps.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
